@@ rtl/core/lmx4_pkg.sv @@
`default_nettype none

package lmx4_pkg;

  // Default sizes of the frame stores
  localparam int DEF_MAX_COLS   = 32;
  localparam int DEF_MAX_ROWS   = 1024;
  localparam int DEF_PIXEL_BITS = 16;

  // Fixed field widths of the ports
  localparam int PEAK_ROW_W = 10;
  localparam int PEAK_COL_W = 5;
  localparam int CFG_ROWS_W = 11;
  localparam int CFG_COLS_W = 6;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'b1;

  // Register reset values
  localparam logic [CFG_ROWS_W-1:0] FRAME_ROWS_RST = 11'd16;
  localparam logic [CFG_COLS_W-1:0] FRAME_COLS_RST = 6'd16;

  // Per-cycle control broadcast to one cell
  typedef struct packed {
    logic wr;        // store the incoming pixel in this column
    logic rot;       // row end: newest -> middle -> older
    logic above_en;  // the row above the middle row exists
  } lmx4_cell_ctl_t;

  // Peak verdicts from one cell
  typedef struct packed {
    logic dec;  // middle entry is a peak, incoming pixel below
    logic fl;   // middle entry is a peak of the final row, nothing below
  } lmx4_flags_t;

endpackage

`default_nettype wire

@@ rtl/core/lmx4_cell.sv @@
`default_nettype none

module lmx4_cell import lmx4_pkg::*; #(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  wire logic                         clk,
  input  wire lmx4_cell_ctl_t               ctl,
  input  wire logic signed [PIXEL_BITS-1:0] pixel,
  input  wire logic signed [PIXEL_BITS-1:0] left_mid,
  input  wire logic signed [PIXEL_BITS-1:0] right_mid,
  input  wire logic                         has_left,
  input  wire logic                         has_right,
  output logic signed [PIXEL_BITS-1:0]      mid_q,
  output lmx4_flags_t                       flags
);

  logic signed [PIXEL_BITS-1:0] older_r;
  logic signed [PIXEL_BITS-1:0] middle_r;
  logic signed [PIXEL_BITS-1:0] newest_r;
  logic                         ge_above;
  logic                         ge_below;
  logic                         ge_side;

  // Take the pixel for this column; rotate the three rows at row end
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      newest_r <= pixel;
    end
    if (ctl.rot) begin
      older_r  <= middle_r;
      middle_r <= ctl.wr ? pixel : newest_r;
    end
  end

  // Compare the middle entry with its existing neighbours
  always_comb begin
    ge_above = middle_r >= older_r;
    ge_below = middle_r >= pixel;
    ge_side  = (!has_left || (middle_r >= left_mid)) &&
               (!has_right || (middle_r >= right_mid));
    flags.dec = (!ctl.above_en || ge_above) && ge_below && ge_side;
    flags.fl  = ge_above && ge_side;
  end

  assign mid_q = middle_r;

endmodule

`default_nettype wire

@@ rtl/core/local_maxima_4_neighbour_2d_core.sv @@
`default_nettype none

// Channel  Direction  Payload                                   Accepted when
// in_      input      in_pixel                                  in_valid & in_ready
// out_     output     out_peak_row, out_peak_col, out_run_last  out_valid & out_ready
// cfg_     input      cfg_index, cfg_data                       cfg_wr_en
//
// One pixel per cycle while the output register is free; row r is decided
// as row r+1 streams in, in the column cells, so a pixel other than the final one of a frame gives at most one peak.
// The final pixel of a frame holds the input while the final row's peak flags are
// captured and then scanned one flag a cycle up to the last set one, through the
// single output register; a set flag waits while that register is stalled.
// Reset is synchronous, active low, clears control state only; a write restarts the frame.

module local_maxima_4_neighbour_2d_core import lmx4_pkg::*; #(
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [PIXEL_BITS-1:0] in_pixel,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [PEAK_ROW_W-1:0]             out_peak_row,
  output logic [PEAK_COL_W-1:0]             out_peak_col,
  output logic                              out_run_last,
  input  wire logic                         cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int RCW = $clog2(MAX_ROWS + 1);

  localparam logic [1:0] S_RUN   = 2'd0;
  localparam logic [1:0] S_LOAD  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CFG_ROWS_W-1:0] frame_rows_r;
  logic [CFG_COLS_W-1:0] frame_cols_r;
  logic [RW-1:0]         row_r, row_nxt;
  logic [CW-1:0]         col_r, col_nxt;
  logic [RCW-1:0]        rows_eff;
  logic [CCW-1:0]        cols_eff;

  logic                  out_valid_r, out_valid_nxt;
  logic [RW-1:0]         out_row_r, out_row_nxt;
  logic [CW-1:0]         out_col_r, out_col_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  dec_pend_r, dec_pend_nxt;
  logic [RW-1:0]         dec_row_r, dec_row_nxt;
  logic [CW-1:0]         dec_col_r, dec_col_nxt;
  logic [RW-1:0]         fin_row_r, fin_row_nxt;
  logic [MAX_COLS:0]     mask_r, mask_nxt;
  logic [CCW-1:0]        idx_r, idx_nxt;

  logic                  in_acc;
  logic                  out_free;
  logic                  last_col;
  logic                  last_row;
  logic                  dec_sel;
  logic [MAX_COLS:0]     mask_shift;

  logic signed [PIXEL_BITS-1:0] mid_q   [MAX_COLS];
  logic signed [PIXEL_BITS-1:0] mid_ext [MAX_COLS+2];
  lmx4_cell_ctl_t               cell_ctl [MAX_COLS];
  lmx4_flags_t                  cell_flags [MAX_COLS];
  logic [MAX_COLS-1:0]          dec_vec;
  logic [MAX_COLS-1:0]          fl_vec;

  // Clamp the frame size to the supported range
  always_comb begin
    if (frame_rows_r < CFG_ROWS_W'(2)) begin
      rows_eff = RCW'(2);
    end else if (32'(frame_rows_r) > 32'(MAX_ROWS)) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = RCW'(frame_rows_r);
    end
    if (frame_cols_r < CFG_COLS_W'(2)) begin
      cols_eff = CCW'(2);
    end else if (32'(frame_cols_r) > 32'(MAX_COLS)) begin
      cols_eff = CCW'(MAX_COLS);
    end else begin
      cols_eff = CCW'(frame_cols_r);
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_RUN) && out_free;
  assign in_acc   = in_valid && in_ready;
  assign last_col = (32'(col_r) + 32'd1) == 32'(cols_eff);
  assign last_row = (32'(row_r) + 32'd1) == 32'(rows_eff);

  // Column cells, each seeing the middle entries of its neighbours
  assign mid_ext[0]          = '0;
  assign mid_ext[MAX_COLS+1] = '0;

  for (genvar k = 0; k < MAX_COLS; k++) begin : g_cell
    assign mid_ext[k+1]          = mid_q[k];
    assign cell_ctl[k].wr        = in_acc && (32'(col_r) == 32'(k));
    assign cell_ctl[k].rot       = in_acc && last_col;
    assign cell_ctl[k].above_en  = 32'(row_r) >= 32'd2;
    assign dec_vec[k]            = cell_flags[k].dec;
    assign fl_vec[k]             = cell_flags[k].fl && (32'(k) < 32'(cols_eff));

    lmx4_cell #(
      .PIXEL_BITS (PIXEL_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[k]),
      .pixel     (in_pixel),
      .left_mid  (mid_ext[k]),
      .right_mid (mid_ext[k+2]),
      .has_left  (k > 0),
      .has_right (32'(k + 1) < 32'(cols_eff)),
      .mid_q     (mid_q[k]),
      .flags     (cell_flags[k])
    );
  end

  assign dec_sel    = dec_vec[col_r];
  assign mask_shift = mask_r >> 1;

  // Frame position, decisions and final-row scan
  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    dec_pend_nxt  = dec_pend_r;
    dec_row_nxt   = dec_row_r;
    dec_col_nxt   = dec_col_r;
    fin_row_nxt   = fin_row_r;
    mask_nxt      = mask_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_RUN: begin
        if (in_acc) begin
          if (last_row && last_col) begin
            // hold the decision of the row above until the final row is known
            dec_pend_nxt = dec_sel;
            dec_row_nxt  = row_r - 1'b1;
            dec_col_nxt  = col_r;
            fin_row_nxt  = row_r;
            state_nxt    = S_LOAD;
          end else if ((row_r != '0) && dec_sel) begin
            out_valid_nxt = 1'b1;
            out_row_nxt   = row_r - 1'b1;
            out_col_nxt   = col_r;
            out_last_nxt  = 1'b1;
          end
          if (last_col) begin
            col_nxt = '0;
            row_nxt = last_row ? '0 : row_r + 1'b1;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      S_LOAD: begin
        mask_nxt  = {fl_vec, dec_pend_r};
        idx_nxt   = '0;
        state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        if (out_free || !mask_r[0]) begin
          if (mask_r[0]) begin
            out_valid_nxt = 1'b1;
            out_row_nxt   = (idx_r == '0) ? dec_row_r : fin_row_r;
            out_col_nxt   = (idx_r == '0) ? dec_col_r : CW'(idx_r - 1'b1);
            out_last_nxt  = (mask_shift == '0);
          end
          mask_nxt = mask_shift;
          idx_nxt  = idx_r + 1'b1;
          if (mask_shift == '0) begin
            state_nxt = S_RUN;
          end
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase

    // a register write restarts the frame
    if (cfg_wr_en) begin
      row_nxt   = '0;
      col_nxt   = '0;
      state_nxt = S_RUN;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_RUN;
      row_r        <= '0;
      col_r        <= '0;
      out_valid_r  <= 1'b0;
      frame_rows_r <= FRAME_ROWS_RST;
      frame_cols_r <= FRAME_COLS_RST;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FRAME_ROWS: frame_rows_r <= cfg_data[CFG_ROWS_W-1:0];
          REG_FRAME_COLS: frame_cols_r <= cfg_data[CFG_COLS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk) begin
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_last_r <= out_last_nxt;
    dec_pend_r <= dec_pend_nxt;
    dec_row_r  <= dec_row_nxt;
    dec_col_r  <= dec_col_nxt;
    fin_row_r  <= fin_row_nxt;
    mask_r     <= mask_nxt;
    idx_r      <= idx_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_peak_row = PEAK_ROW_W'(out_row_r);
  assign out_peak_col = PEAK_COL_W'(out_col_r);
  assign out_run_last = out_last_r;

endmodule

`default_nettype wire

@@ rtl/core/lmx4_checker.sv @@
`default_nettype none

module lmx4_checker import lmx4_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [PEAK_ROW_W-1:0] out_peak_row,
  input wire logic [PEAK_COL_W-1:0] out_peak_col,
  input wire logic                  out_run_last
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_peak_row) &&
      $stable(out_peak_col) && $stable(out_run_last))
    else $error("stalled result changed");

  // Take no item while the result register is full and stalled
  a_in_gate: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid || out_ready)
    else $error("input taken over a stalled result");

  // Further results of the same item block the input
  a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |-> !in_ready)
    else $error("input taken inside an unfinished run");

  // Nothing shown straight after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind local_maxima_4_neighbour_2d_core lmx4_checker u_lmx4_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_peak_row (out_peak_row),
  .out_peak_col (out_peak_col),
  .out_run_last (out_run_last)
);

`default_nettype wire
